// File: rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, character codes and the per-character scan rule for the
// python string/comment tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;

    typedef enum logic [2:0] {
        DELIM_NONE = 3'd0,
        DELIM_TDQ  = 3'd1,
        DELIM_TSQ  = 3'd2,
        DELIM_SQ   = 3'd3,
        DELIM_DQ   = 3'd4
    } delim_t;

    typedef enum logic [1:0] {
        CTX_CODE    = 2'd0,
        CTX_STRING  = 2'd1,
        CTX_COMMENT = 2'd2
    } context_t;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } item_t;

    typedef struct packed {
        delim_t     open_delim;
        logic       in_comment;
        logic [1:0] skip_count;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{open_delim: DELIM_NONE,
                                           in_comment: 1'b0,
                                           skip_count: 2'd0};

    // judge one character; triple means the window holds three equal bytes
    function automatic scan_state_t judge_char(scan_state_t st, logic [7:0] ch,
                                               logic triple);
        scan_state_t nx;
        delim_t      tri_code;
        delim_t      one_code;
        nx       = st;
        tri_code = (ch == CH_DQ) ? DELIM_TDQ : DELIM_TSQ;
        one_code = (ch == CH_DQ) ? DELIM_DQ : DELIM_SQ;
        if (st.skip_count != 2'd0) begin
            nx.skip_count = st.skip_count - 2'd1;
        end else if (ch == CH_HASH && st.open_delim == DELIM_NONE) begin
            nx.in_comment = 1'b1;
        end else if (ch == CH_NL) begin
            nx.in_comment = 1'b0;
        end else if (st.in_comment) begin
            // everything else is ignored inside a comment
            nx = st;
        end else if (ch == CH_BSL) begin
            nx.skip_count = 2'd1;
        end else if (ch == CH_DQ || ch == CH_SQ) begin
            if (triple && st.open_delim == DELIM_NONE) begin
                nx.open_delim = tri_code;
                nx.skip_count = 2'd2;
            end else if (triple && st.open_delim == tri_code) begin
                nx.open_delim = DELIM_NONE;
                nx.skip_count = 2'd2;
            end else if (st.open_delim == DELIM_NONE) begin
                nx.open_delim = one_code;
            end else if (st.open_delim == one_code) begin
                nx.open_delim = DELIM_NONE;
            end
        end
        return nx;
    endfunction

endpackage

// File: rtl/core/pst_scan_core.sv
// ----------------------------------------------------------------------------
// pst_scan_core
// Scanner state, two-character lookahead window and end-of-text flush.
// ----------------------------------------------------------------------------
module pst_scan_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  pst_pkg::item_t    item,
    output pst_pkg::context_t end_context
);
    import pst_pkg::*;

    scan_state_t state_reg, state_next;
    logic [7:0]  la0_reg, la0_next;
    logic [7:0]  la1_reg, la1_next;
    logic [1:0]  fill_reg, fill_next;

    scan_state_t st_shift, st_flush0, st_flush1;
    logic        full;

    assign full = (fill_reg == 2'd2);

    always_comb begin
        // oldest byte is judged once the window and the new byte make three
        st_shift = full ? judge_char(state_reg, la0_reg,
                                     (la0_reg == la1_reg) && (la0_reg == item.character))
                        : state_reg;
        la0_next  = la0_reg;
        la1_next  = la1_reg;
        if (full) begin
            la0_next  = la1_reg;
            la1_next  = item.character;
            fill_next = 2'd2;
        end else begin
            if (fill_reg[0]) begin
                la1_next = item.character;
            end else begin
                la0_next = item.character;
            end
            fill_next = fill_reg + 2'd1;
        end
        // end of text: remaining window bytes, no triple test
        st_flush0 = (fill_next != 2'd0) ? judge_char(st_shift, la0_next, 1'b0) : st_shift;
        st_flush1 = (fill_next == 2'd2) ? judge_char(st_flush0, la1_next, 1'b0) : st_flush0;
        if (st_flush1.open_delim != DELIM_NONE) begin
            end_context = CTX_STRING;
        end else if (st_flush1.in_comment) begin
            end_context = CTX_COMMENT;
        end else begin
            end_context = CTX_CODE;
        end
        state_next = st_shift;
        if (item.is_last) begin
            state_next = SCAN_RESET;
            la0_next   = 8'd0;
            la1_next   = 8'd0;
            fill_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
            la0_reg   <= 8'd0;
            la1_reg   <= 8'd0;
            fill_reg  <= 2'd0;
        end else if (step) begin
            state_reg <= state_next;
            la0_reg   <= la0_next;
            la1_reg   <= la1_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// File: rtl/core/python_string_comment_tracker.sv
// ----------------------------------------------------------------------------
// python_string_comment_tracker
// Tracks string and comment context over a python source text and reports
// the context at the end of each text.
// ----------------------------------------------------------------------------
//  channel | ports                        | moves
//  --------+------------------------------+---------------------------------
//  input   | s_valid s_ready s_character  | one source byte per request,
//          | s_is_last                    | is_last closes the text
//  result  | m_valid m_ready              | one end context per text
//          | m_end_context                |
//
//  One character is taken every cycle unless a last character waits behind a
//  stalled result; the result of a text goes from the input register to the
//  result register behind the scan logic once that register is free.
//  Synchronous active-low reset clears the scanner state and both stages.
//  A stalled result only holds up a last character waiting behind it; other
//  characters keep flowing, s_ready follows m_ready in that one case.
module python_string_comment_tracker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_end_context
);
    import pst_pkg::*;

    item_t    in_item_reg;
    logic     in_valid_reg, in_valid_next;
    logic     m_valid_reg, m_valid_next;
    context_t ctx_reg;
    context_t core_ctx;
    logic     advance;

    // a last character can move on only when the result register is free
    assign advance = in_valid_reg && (!in_item_reg.is_last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && in_item_reg.is_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.character <= s_character;
            in_item_reg.is_last   <= s_is_last;
        end
        if (advance && in_item_reg.is_last) begin
            ctx_reg <= core_ctx;
        end
    end

    pst_scan_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_item_reg),
        .end_context (core_ctx)
    );

    assign m_valid       = m_valid_reg;
    assign m_end_context = ctx_reg;

endmodule

// File: rtl/core/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks for the python string/comment tracker, bound to the top.
// ----------------------------------------------------------------------------
module pst_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_end_context
);

    // held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_end_context))
        else $error("result changed while stalled");

    a_ctx_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_end_context != 2'd3)
        else $error("undefined end context");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result side free");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind python_string_comment_tracker pst_checker u_pst_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_end_context (m_end_context)
);
